@@ hdl/lfu_pkg.sv @@
// Package for the LFU cache table: sizes, types and the per-slot command struct.
// Used by lfu_cell and lfu_cache_table_unit; depends on nothing.
package lfu_pkg;
  localparam int NumSlots  = 16;
  localparam int HalfSlots = NumSlots / 2;
  localparam int CountBits = 16;
  localparam int SlotBits  = $clog2(NumSlots);
  localparam int OccBits   = $clog2(NumSlots + 1);
  localparam int CapBits   = 5;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef logic [SlotBits-1:0]  rank_t;
  typedef logic [CountBits-1:0] count_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic        touch;    // raise count, make youngest
    logic        wr_val;   // overwrite value
    logic        evict;    // clear valid
    logic        insert;   // fill as new entry
    logic        age_all;  // all valid entries age by one
    logic        age_lt;   // entries younger than ref_rank age by one
    logic        dec_gt;   // entries older than ref_rank get younger
    rank_t       ref_rank;
    logic [31:0] key;
    logic [31:0] value;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StLookup = 4'b0010,
    StEvict  = 4'b0100,
    StInsert = 4'b1000
  } state_e;
endpackage

@@ hdl/lfu_cell.sv @@
// One cache slot: valid, key, value, use count and age rank.
// Depends on lfu_pkg. Passes the victim candidate to its neighbor each cycle.
module lfu_cell
  import lfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sel_i,
  input  cell_cmd_t   cmd_i,
  input  logic        cand_vld_i,
  input  count_t      cand_cnt_i,
  input  rank_t       cand_rank_i,
  input  logic [SlotBits-1:0] cand_idx_i,
  input  logic [SlotBits-1:0] my_idx_i,
  output logic        cand_vld_o,
  output count_t      cand_cnt_o,
  output rank_t       cand_rank_o,
  output logic [SlotBits-1:0] cand_idx_o,
  output logic        valid_o,
  output logic        match_o,
  output rank_t       rank_o,
  output logic [31:0] value_o
);
  logic        valid_q;
  logic [31:0] key_q, value_q;
  count_t      cnt_q;
  rank_t       rank_q;
  logic        take;

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == cmd_i.key);
  assign rank_o  = rank_q;
  assign value_o = value_q;

  // Candidate chain: keep lower count, or on a tie the older entry.
  always_comb begin
    take = valid_q && (!cand_vld_i || cnt_q < cand_cnt_i ||
                       (cnt_q == cand_cnt_i && rank_q > cand_rank_i));
    cand_vld_o  = cand_vld_i || valid_q;
    cand_cnt_o  = take ? cnt_q : cand_cnt_i;
    cand_rank_o = take ? rank_q : cand_rank_i;
    cand_idx_o  = take ? my_idx_i : cand_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel_i && cmd_i.evict) begin
      valid_q <= 1'b0;
    end else if (sel_i && cmd_i.insert) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.insert) begin
      key_q   <= cmd_i.key;
      value_q <= cmd_i.value;
      cnt_q   <= count_t'(1);
      rank_q  <= '0;
    end else if (sel_i && cmd_i.touch) begin
      if (cmd_i.wr_val) value_q <= cmd_i.value;
      if (cnt_q != CountMax) cnt_q <= cnt_q + count_t'(1);
      rank_q <= '0;
    end else if (valid_q) begin
      if (cmd_i.age_all || (cmd_i.age_lt && rank_q < cmd_i.ref_rank)) begin
        rank_q <= rank_q + rank_t'(1);
      end else if (cmd_i.dec_gt && rank_q > cmd_i.ref_rank) begin
        rank_q <= rank_q - rank_t'(1);
      end
    end
  end
endmodule

@@ hdl/lfu_cache_table_unit.sv @@
// Top level of the LFU cache table: sequencer, chain of slot cells, result port.
// Depends on lfu_pkg and lfu_cell.
//
// channel  | direction | handshake            | payload
// command  | in        | start_i & !busy_o    | opcode_i, lookup_key_i, store_value_i
// result   | out       | result_valid_o       | hit_o, read_value_o
// config   | in        | cfg_we_i             | cfg_wdata_i (capacity_in_use)
//
// A get, or a put of a present key, passes the accept and lookup states; a put
// of a new key adds insert, after evict when full. The victim search runs along
// the cell chain with a register at the middle cell: the first half settles in
// the lookup cycle, the second half in the evict cycle. Reset empties the table
// and sets capacity to 16. A get's result shows for one cycle after the lookup;
// the receiver cannot stall, so busy_o depends only on the sequencer.
module lfu_cache_table_unit
  import lfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic signed [31:0] lookup_key_i,
  input  logic signed [31:0] store_value_i,
  input  logic        cfg_we_i,
  input  logic [CapBits-1:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic signed [31:0] read_value_o
);
  state_e state_q, state_d;
  logic   op_q;
  logic [31:0] key_q, val_q;
  logic [CapBits-1:0] cap_q;
  logic [OccBits-1:0] occ_q, occ_d;
  logic   res_vld_q, res_hit_q;
  logic [31:0] res_val_q;

  cell_cmd_t cmd;
  logic [NumSlots-1:0] sel, valid, match;
  rank_t       rank   [NumSlots];
  logic [31:0] value  [NumSlots];
  logic        c_vld  [NumSlots+1];
  count_t      c_cnt  [NumSlots+1];
  rank_t       c_rank [NumSlots+1];
  logic [SlotBits-1:0] c_idx [NumSlots+1];

  logic                mid_vld_q;
  count_t              mid_cnt_q;
  rank_t               mid_rank_q;
  logic [SlotBits-1:0] mid_idx_q;

  logic hit_any, free_any;
  logic [SlotBits-1:0] hit_idx, free_idx;
  logic [OccBits-1:0] cap_eff;

  assign c_vld[0] = 1'b0;
  assign c_cnt[0] = '0;
  assign c_rank[0] = '0;
  assign c_idx[0] = '0;

  for (genvar g = 0; g < NumSlots; g++) begin : g_cell
    logic                in_vld;
    count_t              in_cnt;
    rank_t               in_rank;
    logic [SlotBits-1:0] in_idx;

    // The second half of the chain starts from the registered midpoint.
    if (g == HalfSlots) begin : g_mid
      assign in_vld  = mid_vld_q;
      assign in_cnt  = mid_cnt_q;
      assign in_rank = mid_rank_q;
      assign in_idx  = mid_idx_q;
    end else begin : g_pass
      assign in_vld  = c_vld[g];
      assign in_cnt  = c_cnt[g];
      assign in_rank = c_rank[g];
      assign in_idx  = c_idx[g];
    end

    lfu_cell u_cell (
      .clk_i, .rst_ni,
      .sel_i(sel[g]), .cmd_i(cmd),
      .cand_vld_i(in_vld), .cand_cnt_i(in_cnt),
      .cand_rank_i(in_rank), .cand_idx_i(in_idx),
      .my_idx_i(SlotBits'(g)),
      .cand_vld_o(c_vld[g+1]), .cand_cnt_o(c_cnt[g+1]),
      .cand_rank_o(c_rank[g+1]), .cand_idx_o(c_idx[g+1]),
      .valid_o(valid[g]), .match_o(match[g]),
      .rank_o(rank[g]), .value_o(value[g])
    );
  end

  // A put that misses leaves the cells untouched in the lookup cycle, so the
  // midpoint taken at its end still fits the table during the evict cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q  <= 1'b0;
      mid_cnt_q  <= '0;
      mid_rank_q <= '0;
      mid_idx_q  <= '0;
    end else begin
      mid_vld_q  <= c_vld[HalfSlots];
      mid_cnt_q  <= c_cnt[HalfSlots];
      mid_rank_q <= c_rank[HalfSlots];
      mid_idx_q  <= c_idx[HalfSlots];
    end
  end

  always_comb begin
    hit_any = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (match[i]) begin hit_any = 1'b1; hit_idx = SlotBits'(i); end
      if (!valid[i]) begin free_any = 1'b1; free_idx = SlotBits'(i); end
    end
    cap_eff = (32'(cap_q) > NumSlots) ? OccBits'(NumSlots) : OccBits'(cap_q);
  end

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    cmd     = '0;
    cmd.key = key_q;
    cmd.value = val_q;
    sel     = '0;
    case (state_q)
      StIdle: if (start_i) state_d = StLookup;
      StLookup: begin
        state_d = StIdle;
        if (hit_any && (!op_q || cap_eff != '0)) begin
          cmd.touch = 1'b1; cmd.wr_val = op_q; cmd.age_lt = 1'b1;
          cmd.ref_rank = rank[hit_idx];
          sel[hit_idx] = 1'b1;
        end else if (op_q && cap_eff != '0) begin
          state_d = (occ_q >= cap_eff) ? StEvict : StInsert;
        end
      end
      StEvict: begin
        state_d = StInsert;
        if (c_vld[NumSlots]) begin
          cmd.evict = 1'b1; cmd.dec_gt = 1'b1;
          cmd.ref_rank = c_rank[NumSlots];
          sel[c_idx[NumSlots]] = 1'b1;
          occ_d = occ_q - OccBits'(1);
        end
      end
      StInsert: begin
        state_d = StIdle;
        if (free_any) begin
          cmd.insert = 1'b1; cmd.age_all = 1'b1;
          sel[free_idx] = 1'b1;
          occ_d = occ_q + OccBits'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      occ_q     <= '0;
      cap_q     <= CapBits'(16);
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      res_vld_q <= (state_q == StLookup) && !op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
    if (state_q == StLookup) begin
      res_hit_q <= hit_any;
      res_val_q <= hit_any ? value[hit_idx] : 32'd0;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_vld_q;
  assign hit_o          = res_hit_q;
  assign read_value_o   = res_val_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= NumSlots) else $error("occupancy above slot count");
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) == $countones(valid)) else $error("occupancy differs from valid slots");
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("key present in two slots");
  a_res_after_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StLookup) && !op_q)
    else $error("result without a get");
`endif
endmodule
